### hw/rtl/bpdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the buck PI duty controller.
// Used by bpdc_volt_scale, bpdc_ser_mul and buck_pi_duty_controller.

package bpdc_pkg;

  // field widths
  localparam int ADC_W     = 12;
  localparam int FRAC_BITS = 16;
  localparam int VOLT_W    = 21;
  localparam int COEF_W    = 17;
  localparam int DUTY_W    = 17;
  localparam int CMP_W     = 16;
  localparam int STAT_W    = 2;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_NOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 3'd5;

  // reset values of the config registers
  localparam logic [VOLT_W-1:0]        RST_REF_VOLTAGE = 21'd655360;
  localparam logic signed [COEF_W-1:0] RST_COEF_NOW    = 17'sd3499;
  localparam logic signed [COEF_W-1:0] RST_COEF_PREV   = -17'sd3482;
  localparam logic [DUTY_W-1:0]        RST_DUTY_MIN    = 17'd6554;
  localparam logic [DUTY_W-1:0]        RST_DUTY_MAX    = 17'd58982;
  localparam logic [CMP_W-1:0]         RST_PWM_PERIOD  = 16'd37500;

  // duty of one in Q16
  localparam logic [DUTY_W-1:0] DUTY_ONE = 17'h10000;

  // voltage scaling: volts = y + floor(y / 4095) with y = sample * 30 * 16
  localparam int SCALED_W = 17;             // sample * 30
  localparam int QUOT_W   = 9;              // floor(y / 4095) <= 480
  localparam int REM_W    = 22;
  localparam logic [REM_W-1:0] ADC_FULL = 22'd4095;

  // serial multiplier, signed mcand times signed mplier, one mplier bit per cycle
  localparam int MCAND_W  = 18;
  localparam int MPLIER_W = 22;
  localparam int PROD_W   = MCAND_W + MPLIER_W;
  localparam int ACC_W    = MCAND_W + 1;
  localparam int MCNT_W   = 5;

  // error and duty sum widths
  localparam int ERR_W = 22;
  localparam int SUM_W = 24;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [STAT_W-1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_UPPER = 2'd1,
    CLAMP_LOWER = 2'd2
  } clamp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOLT,
    S_MUL_ERR,
    S_CLAMP,
    S_CMP_GO,
    S_CMP_WAIT,
    S_OUT
  } state_t;

endpackage

### hw/rtl/bpdc_volt_scale.sv
`timescale 1ns / 1ps
// Two-stage scaling of a raw ADC sample to Q16 volts, full scale 30 V.
// Depends on bpdc_pkg.

module bpdc_volt_scale import bpdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADC_W-1:0]  sample,
  output logic              done,
  output logic [VOLT_W-1:0] volts
);

  logic [SCALED_W-1:0] x;
  logic [VOLT_W-1:0]   y;
  logic [VOLT_W-1:0]   t;
  logic [VOLT_W-1:0]   y_r;
  logic [QUOT_W-1:0]   q0_r;
  logic                v1_r;
  logic                done_r;
  logic [VOLT_W-1:0]   volts_r;
  logic [REM_W-1:0]    mult_q0;
  logic [REM_W-1:0]    rem;
  logic                q_inc;

  // stage 1: y = sample*480, quotient estimate q0 = (y + y/4096) / 4096, short by at most one
  assign x = (SCALED_W'(sample) << 5) - (SCALED_W'(sample) << 1);
  assign y = {x, 4'b0000};
  assign t = y + (y >> 12);

  // stage 2: remainder check fixes the estimate, then volts = y + y/4095
  assign mult_q0 = (REM_W'(q0_r) << 12) - REM_W'(q0_r);
  assign rem     = REM_W'(y_r) - mult_q0;
  assign q_inc   = (rem >= ADC_FULL);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      y_r  <= y;
      q0_r <= t[VOLT_W-1:12];
    end
    if (v1_r) begin
      volts_r <= y_r + VOLT_W'(q0_r) + VOLT_W'(q_inc);
    end
  end

  assign done  = done_r;
  assign volts = volts_r;

endmodule

### hw/rtl/bpdc_ser_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add with
// a subtract on the sign bit. Depends on bpdc_pkg.

module bpdc_ser_mul import bpdc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [MCAND_W-1:0]  mcand,
  input  logic signed [MPLIER_W-1:0] mplier,
  output mul_stat_t                  stat,
  output logic signed [PROD_W-1:0]   product
);

  localparam logic [MCNT_W-1:0] LAST_STEP = MCNT_W'(MPLIER_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [MCNT_W-1:0]   cnt_r;
  logic [MCAND_W-1:0]  m_r;
  logic [ACC_W-1:0]    acc_r;
  logic [MPLIER_W-1:0] q_r;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    sum;
  logic                last;

  // partial product step; the sign bit of the multiplier weighs negative
  assign last   = (cnt_r == LAST_STEP);
  assign addend = q_r[0] ? {m_r[MCAND_W-1], m_r} : '0;
  assign sum    = last ? (acc_r - addend) : (acc_r + addend);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: arithmetic shift right of {acc, q} each step
  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= mcand;
      acc_r <= '0;
      q_r   <= mplier;
    end else if (busy_r) begin
      acc_r <= {sum[ACC_W-1], sum[ACC_W-1:1]};
      q_r   <= {sum[0], q_r[MPLIER_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {acc_r[MCAND_W-1:0], q_r};

endmodule

### hw/rtl/buck_pi_duty_controller.sv
`timescale 1ns / 1ps
// Buck converter duty controller top: velocity-form PI with duty clamp.
// Depends on bpdc_pkg, bpdc_volt_scale and bpdc_ser_mul.

// One ADC sample is taken per beat on the in_ channel and gives exactly one
// result beat on the out_ channel. The sample is scaled to Q16 volts in the
// scaler, then the two error products run side by side on bit-serial
// multipliers (one multiplier bit per cycle), the duty is summed (sum_r) and
// clamped (duty_acc_r), and the compare count period*(1-duty) takes a further
// serial multiply. One sample is in flight at a time; in_ready is high whenever
// the block is idle, even while the last result waits in the output register.
// Config registers are written through cfg_we/cfg_index/cfg_wdata with no wait
// state and should only be changed between samples.

module buck_pi_duty_controller import bpdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADC_W-1:0]      in_adc_sample,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CMP_W-1:0]      out_compare_value,
  output logic [DUTY_W-1:0]     out_duty_fraction,
  output logic [VOLT_W-1:0]     out_measured_voltage,
  output logic [STAT_W-1:0]     out_clamp_status,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // config registers
  logic [VOLT_W-1:0]        ref_voltage_r;
  logic signed [COEF_W-1:0] coef_now_r;
  logic signed [COEF_W-1:0] coef_prev_r;
  logic [DUTY_W-1:0]        duty_min_r;
  logic [DUTY_W-1:0]        duty_max_r;
  logic [CMP_W-1:0]         pwm_period_r;

  // loop state
  logic [VOLT_W-1:0] last_voltage_r;
  logic [DUTY_W-1:0] duty_acc_r;
  clamp_t            status_r;
  clamp_t            status_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DUTY_W-1:0] duty_nxt;

  state_t state_r;
  state_t state_nxt;

  // output register
  logic              out_valid_r;
  logic [CMP_W-1:0]  out_cmp_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic [VOLT_W-1:0] out_volt_r;
  clamp_t            out_stat_r;

  // unit hookup
  logic                       vs_start;
  logic                       vs_done;
  logic [VOLT_W-1:0]          vs_volts;
  logic                       mul0_start;
  logic                       mul1_start;
  logic signed [MCAND_W-1:0]  mul0_mcand;
  logic signed [MPLIER_W-1:0] mul0_mplier;
  logic signed [MCAND_W-1:0]  mul1_mcand;
  logic signed [MPLIER_W-1:0] mul1_mplier;
  mul_stat_t                  mul0_stat;
  mul_stat_t                  mul1_stat;
  logic signed [PROD_W-1:0]   mul0_product;
  logic signed [PROD_W-1:0]   mul1_product;

  logic [ERR_W-1:0]  e_now;
  logic [ERR_W-1:0]  e_prev;
  logic [DUTY_W-1:0] one_minus_duty;

  // handshake-driven control
  logic in_fire;
  logic out_load;
  logic sum_load;
  logic clamp_load;
  logic err_start;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and step controls
  always_comb begin
    state_nxt  = state_r;
    vs_start   = 1'b0;
    err_start  = 1'b0;
    sum_load   = 1'b0;
    clamp_load = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          vs_start  = 1'b1;
          state_nxt = S_VOLT;
        end
      end
      S_VOLT: begin
        if (vs_done) begin
          err_start = 1'b1;
          state_nxt = S_MUL_ERR;
        end
      end
      S_MUL_ERR: begin
        if (mul0_stat.done) begin
          sum_load  = 1'b1;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        clamp_load = 1'b1;
        state_nxt  = S_CMP_GO;
      end
      S_CMP_GO: begin
        state_nxt = S_CMP_WAIT;
      end
      S_CMP_WAIT: begin
        if (mul0_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_voltage_r <= RST_REF_VOLTAGE;
      coef_now_r    <= RST_COEF_NOW;
      coef_prev_r   <= RST_COEF_PREV;
      duty_min_r    <= RST_DUTY_MIN;
      duty_max_r    <= RST_DUTY_MAX;
      pwm_period_r  <= RST_PWM_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_VOLTAGE: ref_voltage_r <= cfg_wdata[VOLT_W-1:0];
        CFG_COEF_NOW:    coef_now_r    <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_PREV:   coef_prev_r   <= cfg_wdata[COEF_W-1:0];
        CFG_DUTY_MIN:    duty_min_r    <= cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_MAX:    duty_max_r    <= cfg_wdata[DUTY_W-1:0];
        CFG_PWM_PERIOD:  pwm_period_r  <= cfg_wdata[CMP_W-1:0];
        default: ;
      endcase
    end
  end

  // voltage scaling
  bpdc_volt_scale u_volt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (vs_start),
    .sample (in_adc_sample),
    .done   (vs_done),
    .volts  (vs_volts)
  );

  // errors against the reference; e_prev uses the voltage of the previous sample
  assign e_now  = {1'b0, ref_voltage_r} - {1'b0, vs_volts};
  assign e_prev = {1'b0, ref_voltage_r} - {1'b0, last_voltage_r};

  // 1 - duty, zero when the duty reaches one
  assign one_minus_duty = duty_acc_r[DUTY_W-1] ? '0 : (DUTY_ONE - duty_acc_r);

  // multiplier 0: current error, then the compare count
  assign mul0_start  = err_start || (state_r == S_CMP_GO);
  assign mul0_mcand  = (state_r == S_CMP_GO) ? {2'b00, pwm_period_r}
                                              : {coef_now_r[COEF_W-1], coef_now_r};
  assign mul0_mplier = (state_r == S_CMP_GO) ? {5'b00000, one_minus_duty} : e_now;

  // multiplier 1: previous error
  assign mul1_start  = err_start;
  assign mul1_mcand  = {coef_prev_r[COEF_W-1], coef_prev_r};
  assign mul1_mplier = e_prev;

  bpdc_ser_mul u_mul0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul0_start),
    .mcand   (mul0_mcand),
    .mplier  (mul0_mplier),
    .stat    (mul0_stat),
    .product (mul0_product)
  );

  bpdc_ser_mul u_mul1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul1_start),
    .mcand   (mul1_mcand),
    .mplier  (mul1_mplier),
    .stat    (mul1_stat),
    .product (mul1_product)
  );

  // duty update, each product floored on its own by the arithmetic shift
  assign sum_nxt = SUM_W'(duty_acc_r)
                 + mul0_product[PROD_W-1:FRAC_BITS]
                 + mul1_product[PROD_W-1:FRAC_BITS];

  // clamp: upper limit tested first
  always_comb begin
    duty_nxt   = sum_r[DUTY_W-1:0];
    status_nxt = CLAMP_NONE;
    if ($signed(sum_r) > $signed(SUM_W'(duty_max_r))) begin
      duty_nxt   = duty_max_r;
      status_nxt = CLAMP_UPPER;
    end else if ($signed(sum_r) < $signed(SUM_W'(duty_min_r))) begin
      duty_nxt   = duty_min_r;
      status_nxt = CLAMP_LOWER;
    end
  end

  // loop state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_voltage_r <= '0;
      duty_acc_r     <= '0;
      status_r       <= CLAMP_NONE;
    end else begin
      if (err_start) begin
        last_voltage_r <= vs_volts;
      end
      if (clamp_load) begin
        duty_acc_r <= duty_nxt;
        status_r   <= status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_load) begin
      sum_r <= sum_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmp_r  <= mul0_product[FRAC_BITS+CMP_W-1:FRAC_BITS];
      out_duty_r <= duty_acc_r;
      out_volt_r <= last_voltage_r;
      out_stat_r <= status_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_compare_value    = out_cmp_r;
  assign out_duty_fraction    = out_duty_r;
  assign out_measured_voltage = out_volt_r;
  assign out_clamp_status     = out_stat_r;

  // multiplier 0 finishes only where the sequencer waits for it
  a_mul0_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul0_stat.done |-> (state_r == S_MUL_ERR || state_r == S_CMP_WAIT))
    else $error("multiplier 0 finished outside a wait state");

  // both error products finish together
  a_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_ERR && mul0_stat.done) |-> mul1_stat.done)
    else $error("error multipliers out of step");

  // multiplier 1 only runs during the error phase
  a_mul1_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul1_stat.busy |-> (state_r == S_MUL_ERR))
    else $error("multiplier 1 busy outside the error phase");

  // clamped duty lies within ordered limits
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_GO && $past(duty_min_r) <= $past(duty_max_r)) |->
    (duty_acc_r >= $past(duty_min_r) && duty_acc_r <= $past(duty_max_r)))
    else $error("clamped duty outside limits");

  // upper clamp status goes with the upper limit
  a_upper_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_GO && status_r == CLAMP_UPPER) |-> duty_acc_r == $past(duty_max_r))
    else $error("upper clamp status without duty at upper limit");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for buck_pi_duty_controller: directed and random ADC sample beats,
// checked against a Q16 predictor of the PI duty update. Needs bpdc_pkg and the RTL.

module tb_top;
  import bpdc_pkg::*;

  localparam logic [VOLT_W-1:0] VOLT_FULL = 21'd1966080;  // 30 V in Q16
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct {
    logic [VOLT_W-1:0]        ref_volts;
    logic signed [COEF_W-1:0] gain_now;
    logic signed [COEF_W-1:0] gain_prev;
    logic [DUTY_W-1:0]        duty_lo;
    logic [DUTY_W-1:0]        duty_hi;
    logic [CMP_W-1:0]         period;
  } ctrl_cfg_t;

  typedef struct {
    logic [CMP_W-1:0]  compare;
    logic [DUTY_W-1:0] duty;
    logic [VOLT_W-1:0] volts;
    clamp_t            clamp;
  } pwm_update_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADC_W-1:0]      in_adc_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CMP_W-1:0]      out_compare_value;
  logic [DUTY_W-1:0]     out_duty_fraction;
  logic [VOLT_W-1:0]     out_measured_voltage;
  logic [STAT_W-1:0]     out_clamp_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REF_VOLTAGE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and loop state
  ctrl_cfg_t         ctrl;
  logic [VOLT_W-1:0] last_volts;
  logic [DUTY_W-1:0] duty_held;

  logic [ADC_W-1:0] adc_sample_q[$];
  pwm_update_t      pwm_update_q[$];
  pwm_update_t      want;
  int               samples_issued = 0;
  int               samples_taken = 0;
  int               mismatches = 0;
  logic             in_fire = 1'b0;
  logic             idle_on = 1'b1;
  int               tx_gap = 0;
  int               rx_gap = 0;
  int               hold_left = 0;
  int               long_stall_go = 0;
  int               long_stall_seen = 0;

  buck_pi_duty_controller i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_adc_sample        (in_adc_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_compare_value    (out_compare_value),
    .out_duty_fraction    (out_duty_fraction),
    .out_measured_voltage (out_measured_voltage),
    .out_clamp_status     (out_clamp_status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // scale the sample, run the velocity-form update, clamp, derive the compare count
  function automatic pwm_update_t predict_pwm_update(input logic [ADC_W-1:0] sample);
    pwm_update_t r;
    longint volts;
    longint err_now;
    longint err_prev;
    longint duty;
    longint cmp_full;
    volts = ((longint'(sample) * 30) << FRAC_BITS) / ((longint'(1) << ADC_W) - 1);
    r.volts = volts[VOLT_W-1:0];
    err_now = longint'(ctrl.ref_volts) - longint'(r.volts);
    err_prev = longint'(ctrl.ref_volts) - longint'(last_volts);
    // each product floored on its own (arithmetic shift rounds toward minus infinity)
    duty = longint'(duty_held)
         + ((longint'(ctrl.gain_now) * err_now) >>> FRAC_BITS)
         + ((longint'(ctrl.gain_prev) * err_prev) >>> FRAC_BITS);
    r.clamp = CLAMP_NONE;
    // upper limit tested first: with crossed limits, a duty above it still clamps upper
    if (duty > longint'(ctrl.duty_hi)) begin
      duty = longint'(ctrl.duty_hi);
      r.clamp = CLAMP_UPPER;
    end else if (duty < longint'(ctrl.duty_lo)) begin
      duty = longint'(ctrl.duty_lo);
      r.clamp = CLAMP_LOWER;
    end
    r.duty = duty[DUTY_W-1:0];
    if (r.duty >= DUTY_ONE) begin
      r.compare = '0;
    end else begin
      cmp_full = (longint'(ctrl.period) * ((longint'(1) << FRAC_BITS) - longint'(r.duty)))
                 >> FRAC_BITS;
      r.compare = cmp_full[CMP_W-1:0];
    end
    last_volts = r.volts;
    duty_held = r.duty;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // monitor: register writes, accepted samples and result beats
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      ctrl.ref_volts = RST_REF_VOLTAGE;
      ctrl.gain_now = RST_COEF_NOW;
      ctrl.gain_prev = RST_COEF_PREV;
      ctrl.duty_lo = RST_DUTY_MIN;
      ctrl.duty_hi = RST_DUTY_MAX;
      ctrl.period = RST_PWM_PERIOD;
      last_volts = '0;
      duty_held = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF_VOLTAGE: ctrl.ref_volts = cfg_wdata[VOLT_W-1:0];
          CFG_COEF_NOW:    ctrl.gain_now = cfg_wdata[COEF_W-1:0];
          CFG_COEF_PREV:   ctrl.gain_prev = cfg_wdata[COEF_W-1:0];
          CFG_DUTY_MIN:    ctrl.duty_lo = cfg_wdata[DUTY_W-1:0];
          CFG_DUTY_MAX:    ctrl.duty_hi = cfg_wdata[DUTY_W-1:0];
          CFG_PWM_PERIOD:  ctrl.period = cfg_wdata[CMP_W-1:0];
          default: ;
        endcase
      end
      // check the result beat before queuing the new prediction
      if (out_valid && out_ready) begin
        if (pwm_update_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual cmp %0d duty %0d",
                   $time, out_compare_value, out_duty_fraction);
          mismatches++;
        end else begin
          want = pwm_update_q.pop_front();
          check_field("compare_value", 32'(want.compare), 32'(out_compare_value));
          check_field("duty_fraction", 32'(want.duty), 32'(out_duty_fraction));
          check_field("measured_voltage", 32'(want.volts), 32'(out_measured_voltage));
          check_field("clamp_status", 32'(want.clamp), 32'(out_clamp_status));
        end
      end
      if (in_valid && in_ready) begin
        pwm_update_q.push_back(predict_pwm_update(in_adc_sample));
        samples_taken++;
      end
    end
  end

  // sample driver: holds a beat until taken, with random idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // beat still pending
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (adc_sample_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      tx_gap = $urandom_range(0, 7);
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_adc_sample <= adc_sample_q.pop_front();
    end
  end

  // result receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (long_stall_seen != long_stall_go) begin
      long_stall_seen = long_stall_go;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer(input logic [ADC_W-1:0] sample);
    adc_sample_q.push_back(sample);
    samples_issued++;
  endtask

  // wait until every sample is taken and every result beat has come back
  task automatic drain_results();
    @(negedge clk);
    while (samples_taken != samples_issued || pwm_update_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_ctrl_cfg(input ctrl_cfg_t c);
    write_reg(CFG_REF_VOLTAGE, c.ref_volts);
    write_reg(CFG_COEF_NOW, CFG_DATA_W'(c.gain_now));
    write_reg(CFG_COEF_PREV, CFG_DATA_W'(c.gain_prev));
    write_reg(CFG_DUTY_MIN, CFG_DATA_W'(c.duty_lo));
    write_reg(CFG_DUTY_MAX, CFG_DATA_W'(c.duty_hi));
    write_reg(CFG_PWM_PERIOD, CFG_DATA_W'(c.period));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly plausible PI gains and ordered limits, sometimes extremes or crossed limits
  function automatic ctrl_cfg_t random_ctrl_cfg();
    ctrl_cfg_t c;
    int pick;
    int k;
    int lo;
    int hi;
    pick = $urandom_range(0, 5);
    c.ref_volts = (pick == 0) ? '0 : (pick == 1) ? VOLT_FULL :
                  VOLT_W'($urandom_range(0, VOLT_FULL));
    if ($urandom_range(0, 3) == 0) begin
      c.gain_now = COEF_W'($urandom_range(0, 131071));
      c.gain_prev = COEF_W'($urandom_range(0, 131071));
    end else begin
      k = $urandom_range(0, 8000);
      c.gain_now = COEF_W'(k);
      c.gain_prev = COEF_W'($urandom_range(0, 300) - k);
    end
    lo = $urandom_range(0, 32768);
    hi = $urandom_range(lo, 65536);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      lo = 0;
      hi = 65536;
    end
    if (pick == 1) begin
      c.duty_lo = DUTY_W'(hi);
      c.duty_hi = DUTY_W'(lo);
    end else begin
      c.duty_lo = DUTY_W'(lo);
      c.duty_hi = DUTY_W'(hi);
    end
    pick = $urandom_range(0, 5);
    c.period = (pick == 0) ? 16'd1 : (pick == 1) ? 16'd65535 :
               CMP_W'($urandom_range(1, 65535));
    return c;
  endfunction

  initial begin : stim
    ctrl_cfg_t c;
    int track;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first step after reset, sample extremes, near the 10 V point
    offer(12'd0);    offer(12'd4095); offer(12'd4095); offer(12'd0);
    offer(12'd0);    offer(12'd1);    offer(12'd4094); offer(12'd2048);
    offer(12'd1365); offer(12'd1365); offer(12'd1366); offer(12'd1364);
    offer(12'h555);  offer(12'hAAA);
    drain_results();

    // extreme gains, widest limits: duty reaches one, compare drops to zero
    c.ref_volts = VOLT_FULL;
    c.gain_now = 17'sd65535;
    c.gain_prev = -17'sd65536;
    c.duty_lo = '0;
    c.duty_hi = DUTY_ONE;
    c.period = 16'd65535;
    load_ctrl_cfg(c);
    @(posedge clk);
    offer(12'd0); offer(12'd0); offer(12'd4095); offer(12'd4095);
    drain_results();

    // crossed limits, minimum period, opposite gain extremes
    c.ref_volts = '0;
    c.gain_now = -17'sd65536;
    c.gain_prev = 17'sd65535;
    c.duty_lo = DUTY_ONE;
    c.duty_hi = '0;
    c.period = 16'd1;
    load_ctrl_cfg(c);
    @(posedge clk);
    offer(12'd4095); offer(12'd0); offer(12'd2000); offer(12'd4095);
    drain_results();

    // random phases: sample walks around the setpoint, with some wild samples
    for (int ph = 0; ph < 8; ph++) begin
      c = random_ctrl_cfg();
      load_ctrl_cfg(c);
      @(posedge clk);
      idle_on = (ph != 2 && ph != 7);
      if (ph == 3) long_stall_go++;
      track = int'((longint'(c.ref_volts) * 4095) / VOLT_FULL);
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          track = track + $urandom_range(0, 64) - 32;
          if (track < 0) track = 0;
          if (track > 4095) track = 4095;
          offer(track[ADC_W-1:0]);
        end else begin
          offer(ADC_W'($urandom_range(0, 4095)));
        end
      end
      drain_results();
    end

    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
